/* src/bcp_pkg.sv */
// ----------------------------------------------------------------------------
// bcp_pkg
// Shared constants for the cascaded balance controller: widths, register
// indexes, reset values and divisor constants.
// ----------------------------------------------------------------------------
package bcp_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN_P   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN_D   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN_P   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN_P   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN_D   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BALANCE_OFFSET = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd7;

  // register reset values
  localparam logic [15:0] RST_ANGLE_GAIN_P   = 16'd20890;
  localparam logic [15:0] RST_ANGLE_GAIN_D   = 16'd123;
  localparam logic [15:0] RST_SPEED_GAIN_P   = 16'd2048;
  localparam logic [15:0] RST_STEER_GAIN_P   = 16'd40960;
  localparam logic [15:0] RST_STEER_GAIN_D   = 16'd25;
  localparam logic [15:0] RST_BALANCE_OFFSET = 16'd512;
  localparam logic [14:0] RST_DRIVE_LIMIT    = 15'd40;
  localparam logic [16:0] RST_INTEGRAL_LIMIT = 17'd20000;

  localparam int MAX_SPEED_DEF = 20;

  // serial arithmetic units
  localparam int MUL_W   = 48;   // accumulator width
  localparam int GAIN_W  = 16;   // multiplier operand width
  localparam int DIV_W   = 29;   // dividend / quotient width
  localparam int DEN_W   = 8;    // divisor width
  localparam logic [DEN_W-1:0] DEN_TEN         = 8'd10;
  localparam logic [DEN_W-1:0] DEN_TWO_HUNDRED = 8'd200;

endpackage

/* src/bcp_in_if.sv */
// ----------------------------------------------------------------------------
// bcp_in_if
// Input channel: one control tick of sensor readings and buttons.
// ----------------------------------------------------------------------------
interface bcp_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] left_count;
  logic signed [15:0] right_count;
  logic signed [15:0] roll_angle;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_z;
  logic              go_forward;
  logic              go_back;
  logic              steer_left;
  logic              steer_right;
  logic              clear_integral;

  modport source (output valid, left_count, right_count, roll_angle, gyro_x, gyro_z,
                  go_forward, go_back, steer_left, steer_right, clear_integral,
                  input ready);
  modport sink   (input valid, left_count, right_count, roll_angle, gyro_x, gyro_z,
                  go_forward, go_back, steer_left, steer_right, clear_integral,
                  output ready);
endinterface

/* src/bcp_out_if.sv */
// ----------------------------------------------------------------------------
// bcp_out_if
// Result channel: left and right motor commands.
// ----------------------------------------------------------------------------
interface bcp_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] motor_left;
  logic signed [15:0] motor_right;

  modport source (output valid, motor_left, motor_right, input ready);
  modport sink   (input valid, motor_left, motor_right, output ready);
endinterface

/* src/balance_cascade_pid.sv */
// ----------------------------------------------------------------------------
// balance_cascade_pid
// Cascaded velocity PI / angle PD / turn PD controller for a two-wheeled
// balancing robot, built on a shared bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
// One tick in, one motor pair out. Each tick runs from acceptance to the
// result through two serial divisions (the 0.3/0.7 filter and the velocity
// scaling by 200) and four shift-add products on one shared multiplier,
// with sequencing states for unit start-up and hand-over. A new tick is
// taken once the sequencer is back in idle, the cycle after the result is
// registered, so a new tick is not accepted before the last one is through.
// This holds even while the last result still waits in the output register.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while no tick is in flight, the block does not enforce this.
// ----------------------------------------------------------------------------
module balance_cascade_pid #(
  parameter int MAX_TARGET_SPEED = bcp_pkg::MAX_SPEED_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bcp_in_if.sink                          in_ch,
  bcp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [bcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bcp_pkg::*;

  localparam logic signed [6:0] MAX_TS = 7'(MAX_TARGET_SPEED);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DIV1, S_INT, S_MUL1, S_DIV2, S_SP,
    S_MUL2, S_MUL3, S_MUL4, S_OUT
  } state_t;

  // configuration registers
  logic [15:0]        agp_r, agd_r, sgp_r, stp_r, std_r;
  logic signed [15:0] off_r;
  logic [14:0]        dlim_r;
  logic [16:0]        ilim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agp_r  <= RST_ANGLE_GAIN_P;
      agd_r  <= RST_ANGLE_GAIN_D;
      sgp_r  <= RST_SPEED_GAIN_P;
      stp_r  <= RST_STEER_GAIN_P;
      std_r  <= RST_STEER_GAIN_D;
      off_r  <= RST_BALANCE_OFFSET;
      dlim_r <= RST_DRIVE_LIMIT;
      ilim_r <= RST_INTEGRAL_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ANGLE_GAIN_P:   agp_r  <= cfg_data[15:0];
        REG_ANGLE_GAIN_D:   agd_r  <= cfg_data[15:0];
        REG_SPEED_GAIN_P:   sgp_r  <= cfg_data[15:0];
        REG_STEER_GAIN_P:   stp_r  <= cfg_data[15:0];
        REG_STEER_GAIN_D:   std_r  <= cfg_data[15:0];
        REG_BALANCE_OFFSET: off_r  <= cfg_data[15:0];
        REG_DRIVE_LIMIT:    dlim_r <= cfg_data[14:0];
        REG_INTEGRAL_LIMIT: ilim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state and registers
  state_t             state_r;
  logic signed [5:0]  ts_r;
  logic signed [17:0] fe_r;
  logic signed [17:0] ei_r;
  logic signed [15:0] left_r, right_r, roll_r, gx_r, gz_r;
  logic               lf_r, rt_r, clr_r;
  logic               neg_r;
  logic signed [21:0] vel_r;
  logic signed [15:0] drive_r;
  logic               out_valid_r;
  logic signed [15:0] mleft_r, mright_r;

  logic                    mul_go_r;
  logic signed [MUL_W-1:0] mul_a_r;
  logic [GAIN_W-1:0]       mul_b_r;
  logic signed [MUL_W-1:0] mul_c_r;
  logic                    mul_done;
  logic signed [MUL_W-1:0] mul_acc;

  logic                    div_go_r;
  logic [DIV_W-1:0]        div_num_r;
  logic [DEN_W-1:0]        div_den_r;
  logic                    div_done;
  logic [DIV_W-1:0]        div_q;

  bcp_ser_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_go_r),
    .mcand    (mul_a_r),
    .mplier   (mul_b_r),
    .acc_init (mul_c_r),
    .done     (mul_done),
    .acc      (mul_acc)
  );

  bcp_ser_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (div_num_r),
    .divisor  (div_den_r),
    .done     (div_done),
    .quotient (div_q)
  );

  logic               accept;
  logic signed [6:0]  ts_base, ts_sum, ts_nxt;
  logic signed [17:0] err;
  logic signed [21:0] tmix;
  logic [21:0]        tmag;
  logic signed [17:0] filt;
  logic signed [18:0] isum, ilim19;
  logic signed [17:0] integ;
  logic signed [26:0] spd;
  logic [MUL_W-1:0]   amag;
  logic signed [30:0] sp, dang;
  logic signed [MUL_W-1:0] shr20, shr12, dlim48, ang, turn, ml, mr;
  logic signed [MUL_W-1:0] dir_init;
  logic [GAIN_W-1:0]  kd_eff;

  assign accept = in_ch.valid && in_ch.ready;

  // per-stage arithmetic
  always_comb begin
    // target speed ramp
    ts_base = (!in_ch.go_forward && !in_ch.go_back) ? 7'sd0 : 7'(ts_r);
    ts_sum  = ts_base + (in_ch.go_forward ? 7'sd1 : 7'sd0)
                      - (in_ch.go_back ? 7'sd1 : 7'sd0);
    if (ts_sum > MAX_TS) ts_nxt = MAX_TS;
    else if (ts_sum < -MAX_TS) ts_nxt = -MAX_TS;
    else ts_nxt = ts_sum;

    // speed error and low-pass numerator
    err  = 18'(left_r) + 18'(right_r) - 18'(ts_r);
    tmix = 22'(err) * 22'sd3 + 22'(fe_r) * 22'sd7;
    tmag = tmix[21] ? 22'(-tmix) : 22'(tmix);
    filt = neg_r ? -$signed(div_q[17:0]) : $signed(div_q[17:0]);

    // integral with symmetric clamp, then clear
    isum   = 19'(ei_r) + 19'(fe_r);
    ilim19 = $signed({2'b00, ilim_r});
    if (isum > ilim19) integ = 18'(ilim19);
    else if (isum < -ilim19) integ = 18'(-ilim19);
    else integ = 18'(isum);
    if (clr_r) integ = 18'sd0;
    spd = 27'(fe_r) * 27'sd200 + 27'(integ);

    // magnitude for the velocity scaling
    amag = mul_acc[MUL_W-1] ? MUL_W'(-mul_acc) : MUL_W'(mul_acc);

    // balance setpoint and angle error
    sp   = (31'(vel_r) <<< 8) + 31'(off_r);
    dang = 31'(roll_r) - sp;

    // angle drive, truncated toward zero and clamped
    shr20 = (mul_acc >>> 20) +
            ((mul_acc[MUL_W-1] && (|mul_acc[19:0])) ? 48'sd1 : 48'sd0);
    dlim48 = $signed(MUL_W'({1'b0, dlim_r}));
    if (shr20 > dlim48) ang = dlim48;
    else if (shr20 < -dlim48) ang = -dlim48;
    else ang = shr20;

    // turn term set-up: left wins, no damping while turning
    kd_eff = (lf_r || rt_r) ? '0 : std_r;
    if (lf_r) dir_init = -$signed(MUL_W'(stp_r));
    else if (rt_r) dir_init = $signed(MUL_W'(stp_r));
    else dir_init = '0;

    // turn term and motor mix
    shr12 = (mul_acc >>> 12) +
            ((mul_acc[MUL_W-1] && (|mul_acc[11:0])) ? 48'sd1 : 48'sd0);
    turn = shr12;
    ml   = 48'(drive_r) - turn;
    mr   = 48'(drive_r) + turn;
  end

  function automatic logic signed [15:0] sat16(input logic signed [MUL_W-1:0] v);
    if (v > 48'sd32767) sat16 = 16'sh7fff;
    else if (v < -48'sd32768) sat16 = 16'sh8000;
    else sat16 = 16'(v);
  endfunction

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ts_r        <= '0;
      fe_r        <= '0;
      ei_r        <= '0;
      out_valid_r <= 1'b0;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
    end else begin
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      // result transfer out; a new result in S_OUT refills the register
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            left_r  <= in_ch.left_count;
            right_r <= in_ch.right_count;
            roll_r  <= in_ch.roll_angle;
            gx_r    <= in_ch.gyro_x;
            gz_r    <= in_ch.gyro_z;
            lf_r    <= in_ch.steer_left;
            rt_r    <= in_ch.steer_right;
            clr_r   <= in_ch.clear_integral;
            ts_r    <= 6'(ts_nxt);
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          neg_r     <= tmix[21];
          div_num_r <= DIV_W'(tmag);
          div_den_r <= DEN_TEN;
          div_go_r  <= 1'b1;
          state_r   <= S_DIV1;
        end
        S_DIV1: begin
          if (div_done) begin
            fe_r    <= filt;
            state_r <= S_INT;
          end
        end
        S_INT: begin
          ei_r     <= integ;
          mul_a_r  <= MUL_W'(spd);
          mul_b_r  <= sgp_r;
          mul_c_r  <= '0;
          mul_go_r <= 1'b1;
          state_r  <= S_MUL1;
        end
        S_MUL1: begin
          if (mul_done) begin
            neg_r     <= mul_acc[MUL_W-1];
            div_num_r <= amag[DIV_W+11:12];
            div_den_r <= DEN_TWO_HUNDRED;
            div_go_r  <= 1'b1;
            state_r   <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            vel_r   <= neg_r ? -$signed(div_q[21:0]) : $signed(div_q[21:0]);
            state_r <= S_SP;
          end
        end
        S_SP: begin
          mul_a_r  <= MUL_W'(dang);
          mul_b_r  <= agp_r;
          mul_c_r  <= '0;
          mul_go_r <= 1'b1;
          state_r  <= S_MUL2;
        end
        S_MUL2: begin
          if (mul_done) begin
            mul_a_r  <= MUL_W'(gx_r) <<< 8;
            mul_b_r  <= agd_r;
            mul_c_r  <= mul_acc;
            mul_go_r <= 1'b1;
            state_r  <= S_MUL3;
          end
        end
        S_MUL3: begin
          if (mul_done) begin
            drive_r  <= 16'(ang);
            mul_a_r  <= MUL_W'(gz_r);
            mul_b_r  <= kd_eff;
            mul_c_r  <= dir_init;
            mul_go_r <= 1'b1;
            state_r  <= S_MUL4;
          end
        end
        S_MUL4: begin
          if (mul_done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            mleft_r     <= sat16(ml);
            mright_r    <= sat16(mr);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.motor_left  = mleft_r;
  assign out_ch.motor_right = mright_r;

  // checks
  a_ts_range: assert property (@(posedge clk) disable iff (!rst_n)
    (7'(ts_r) <= MAX_TS) && (7'(ts_r) >= -MAX_TS))
    else $error("target speed outside its clamp");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !$rose(out_ch.valid))
    else $error("result raised straight after a transfer in");

endmodule

/* src/bcp_ser_mul.sv */
// ----------------------------------------------------------------------------
// bcp_ser_mul
// Bit-serial shift-add multiply-accumulate: one multiplier bit per cycle,
// accumulator preloaded at start.
// ----------------------------------------------------------------------------
module bcp_ser_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [bcp_pkg::MUL_W-1:0]  mcand,
  input  logic [bcp_pkg::GAIN_W-1:0]        mplier,
  input  logic signed [bcp_pkg::MUL_W-1:0]  acc_init,
  output logic                             done,
  output logic signed [bcp_pkg::MUL_W-1:0]  acc
);
  import bcp_pkg::*;

  localparam int CNT_W = $clog2(GAIN_W);

  logic signed [MUL_W-1:0]  mcand_r;
  logic [GAIN_W-1:0]        mplier_r;
  logic signed [MUL_W-1:0]  acc_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     run_r;
  logic                     done_r;

  // shift-add step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        mcand_r  <= mcand;
        mplier_r <= mplier;
        acc_r    <= acc_init;
        cnt_r    <= '0;
        run_r    <= 1'b1;
      end else if (run_r) begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= mcand_r <<< 1;
        mplier_r <= mplier_r >> 1;
        cnt_r    <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(GAIN_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

/* src/bcp_ser_div.sv */
// ----------------------------------------------------------------------------
// bcp_ser_div
// Restoring divider for unsigned magnitudes: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcp_ser_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bcp_pkg::DIV_W-1:0]   dividend,
  input  logic [bcp_pkg::DEN_W-1:0]   divisor,
  output logic                       done,
  output logic [bcp_pkg::DIV_W-1:0]   quotient
);
  import bcp_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  // trial subtract of the next dividend bit
  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= dividend;
        den_r <= divisor;
        rem_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
